>>> design/one_euro_vector_filter_core_assert.svh
// Assertion macros shared by the checker of the one euro vector filter core.
// Each macro expands to one labeled concurrent assertion that is disabled during reset.
`ifndef ONE_EURO_VECTOR_FILTER_CORE_ASSERT_SVH
`define ONE_EURO_VECTOR_FILTER_CORE_ASSERT_SVH

// The consequent must hold at the same clock edge as the antecedent.
`define OEF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("one euro filter core: same-cycle check failed");

// The consequent must hold at the clock edge after the antecedent.
`define OEF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("one euro filter core: next-cycle check failed");

`endif

>>> design/oef_pkg.sv
// ----------------------------------------------------------------------------
// oef_pkg
// Types and constants shared by the one euro vector filter core modules.
// ----------------------------------------------------------------------------
`default_nettype none

package oef_pkg;

	localparam int IO_WIDTH      = 32;
	localparam int DT_WIDTH      = 19;
	localparam int CFG_WIDTH     = 32;
	localparam int CFG_IDX_WIDTH = 2;
	localparam int AXES          = 3;

	localparam logic [CFG_IDX_WIDTH-1:0] CFG_MIN_CUTOFF   = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_BETA         = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_DERIV_CUTOFF = 2'd2;

	localparam logic [CFG_WIDTH-1:0] MIN_CUTOFF_RST   = 32'h0001_0000;
	localparam logic [CFG_WIDTH-1:0] BETA_RST         = 32'h0000_0000;
	localparam logic [CFG_WIDTH-1:0] DERIV_CUTOFF_RST = 32'h0001_0000;

	localparam int RATE_WIDTH  = 40;
	localparam int ALPHA_WIDTH = 16;
	localparam int WPROD_WIDTH = 51;
	localparam int W_WIDTH     = 35;
	localparam int NUM_WIDTH   = 54;
	localparam int DEN_WIDTH   = 55;
	localparam int SUM_WIDTH   = 64;
	localparam int SPEED_WIDTH = 32;
	localparam int DIV_STEPS   = 40;
	localparam int SQRT_STEPS  = 32;
	localparam int CNT_WIDTH   = 6;

	// 2*pi in Q16, the tau scale 2^16 * 10^6, and 10^6.
	localparam logic [18:0]          TWO_PI_Q16 = 19'd411775;
	localparam logic [DEN_WIDTH-1:0] TAU_SCALE  = 55'd65536000000;
	localparam logic [19:0]          MICRO      = 20'd1000000;

	localparam logic signed [RATE_WIDTH-1:0] RATE_MAX = {1'b0, {(RATE_WIDTH-1){1'b1}}};
	localparam logic signed [RATE_WIDTH-1:0] RATE_MIN = {1'b1, {(RATE_WIDTH-1){1'b0}}};

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_WCALC,
		OP_NUM,
		OP_DIV,
		OP_RATE_MUL,
		OP_RATE_ACC,
		OP_SQ,
		OP_SQRT,
		OP_CUT,
		OP_BLEND_MUL,
		OP_BLEND_ACC,
		OP_WRITE
	} oef_op_t;

	typedef struct packed {
		oef_op_t    op;
		logic       alpha_step;
		logic       use_cut;
		logic [1:0] axis;
	} oef_cmd_t;

	typedef struct packed {
		logic fast;
	} oef_status_t;

endpackage

`default_nettype wire

>>> design/oef_in_if.sv
// ----------------------------------------------------------------------------
// oef_in_if
// Sample channel: one position sample with its time step and restart flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface oef_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [oef_pkg::IO_WIDTH-1:0] raw_x;
	logic signed [oef_pkg::IO_WIDTH-1:0] raw_y;
	logic signed [oef_pkg::IO_WIDTH-1:0] raw_z;
	logic        [oef_pkg::DT_WIDTH-1:0] dt_us;
	logic                                restart;

	modport source (output valid, output raw_x, output raw_y, output raw_z,
		output dt_us, output restart, input ready);
	modport sink (input valid, input raw_x, input raw_y, input raw_z,
		input dt_us, input restart, output ready);
endinterface

`default_nettype wire

>>> design/oef_out_if.sv
// ----------------------------------------------------------------------------
// oef_out_if
// Result channel: one filtered position.
// ----------------------------------------------------------------------------
`default_nettype none

interface oef_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [oef_pkg::IO_WIDTH-1:0] out_x;
	logic signed [oef_pkg::IO_WIDTH-1:0] out_y;
	logic signed [oef_pkg::IO_WIDTH-1:0] out_z;

	modport source (output valid, output out_x, output out_y, output out_z, input ready);
	modport sink (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

`default_nettype wire

>>> design/one_euro_vector_filter_core.sv
// ----------------------------------------------------------------------------
// one_euro_vector_filter_core
// Adaptive one euro low-pass filter for a three-axis position stream.
// ----------------------------------------------------------------------------
// One sample is in flight at a time. A sample that passes through (filter
// bypassed, zero time step, or the first sample after reset or restart) goes
// from the branch state straight to the write state; a filtered sample's time
// is set mainly by the 40-step rate division that runs all three axes in
// parallel and the 32-step square root of the speed. The next sample is
// taken as soon as the result is in the output register, even while that
// result still waits for the consumer. Configuration writes take effect on
// the next sample and must be made while the block is idle.
`default_nettype none

module one_euro_vector_filter_core #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	oef_in_if.sink                              sample,
	oef_out_if.source                           filtered,
	input  logic                                wr_en,
	input  logic   [oef_pkg::CFG_IDX_WIDTH-1:0] wr_index,
	input  logic       [oef_pkg::CFG_WIDTH-1:0] wr_data
);
	import oef_pkg::*;

	oef_cmd_t    cmd;
	oef_status_t status;

	oef_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (filtered.valid),
		.out_ready (filtered.ready),
		.status    (status),
		.cmd       (cmd)
	);

	oef_dp #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.raw_x    (sample.raw_x),
		.raw_y    (sample.raw_y),
		.raw_z    (sample.raw_z),
		.dt_us    (sample.dt_us),
		.restart  (sample.restart),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.out_x    (filtered.out_x),
		.out_y    (filtered.out_y),
		.out_z    (filtered.out_z)
	);

endmodule

`default_nettype wire

>>> design/oef_ctrl.sv
// ----------------------------------------------------------------------------
// oef_ctrl
// Sequencer of the filter: steps the datapath through one sample per pass.
// ----------------------------------------------------------------------------
`default_nettype none

module oef_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  oef_pkg::oef_status_t status,
	output oef_pkg::oef_cmd_t    cmd
);
	import oef_pkg::*;

	localparam logic [CNT_WIDTH-1:0] RDIV_LAST  = CNT_WIDTH'(DIV_STEPS - 1);
	localparam logic [CNT_WIDTH-1:0] ADIV_LAST  = CNT_WIDTH'(ALPHA_WIDTH - 1);
	localparam logic [CNT_WIDTH-1:0] ALPHA_END  = CNT_WIDTH'(ALPHA_WIDTH);
	localparam logic [CNT_WIDTH-1:0] SQ_LAST    = CNT_WIDTH'(AXES - 1);
	localparam logic [CNT_WIDTH-1:0] SQRT_LAST  = CNT_WIDTH'(SQRT_STEPS - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_BRANCH,
		S_WCALC1,
		S_NUM1,
		S_RDIV,
		S_RMUL,
		S_RACC,
		S_SQ,
		S_SQRT,
		S_CUT,
		S_WCALC2,
		S_NUM2,
		S_ADIV,
		S_BMUL,
		S_BACC,
		S_WRITE
	} state_t;

	state_t               state_q;
	logic [CNT_WIDTH-1:0] cnt_q;
	logic                 out_valid_q;
	logic                 slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd            = '0;
		cmd.op         = OP_NONE;
		case (state_q)
			S_IDLE:   if (in_valid) cmd.op = OP_LOAD;
			S_WCALC1: cmd.op = OP_WCALC;
			S_NUM1:   cmd.op = OP_NUM;
			S_RDIV: begin
				cmd.op         = OP_DIV;
				cmd.alpha_step = (cnt_q < ALPHA_END);
			end
			S_RMUL:   cmd.op = OP_RATE_MUL;
			S_RACC:   cmd.op = OP_RATE_ACC;
			S_SQ: begin
				cmd.op   = OP_SQ;
				cmd.axis = cnt_q[1:0];
			end
			S_SQRT:   cmd.op = OP_SQRT;
			S_CUT:    cmd.op = OP_CUT;
			S_WCALC2: begin
				cmd.op      = OP_WCALC;
				cmd.use_cut = 1'b1;
			end
			S_NUM2:   cmd.op = OP_NUM;
			S_ADIV: begin
				cmd.op         = OP_DIV;
				cmd.alpha_step = 1'b1;
			end
			S_BMUL:   cmd.op = OP_BLEND_MUL;
			S_BACC:   cmd.op = OP_BLEND_ACC;
			S_WRITE:  if (slot_free) cmd.op = OP_WRITE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// In the write state the output register is refilled below instead.
			if (out_valid_q && out_ready && (state_q != S_WRITE)) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_BRANCH;
				S_BRANCH: state_q <= status.fast ? S_WRITE : S_WCALC1;
				S_WCALC1: state_q <= S_NUM1;
				S_NUM1: begin
					state_q <= S_RDIV;
					cnt_q   <= '0;
				end
				S_RDIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == RDIV_LAST) state_q <= S_RMUL;
				end
				S_RMUL:   state_q <= S_RACC;
				S_RACC: begin
					state_q <= S_SQ;
					cnt_q   <= '0;
				end
				S_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SQ_LAST) begin
						state_q <= S_SQRT;
						cnt_q   <= '0;
					end
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SQRT_LAST) state_q <= S_CUT;
				end
				S_CUT:    state_q <= S_WCALC2;
				S_WCALC2: state_q <= S_NUM2;
				S_NUM2: begin
					state_q <= S_ADIV;
					cnt_q   <= '0;
				end
				S_ADIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ADIV_LAST) state_q <= S_BMUL;
				end
				S_BMUL:   state_q <= S_BACC;
				S_BACC:   state_q <= S_WRITE;
				S_WRITE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/oef_dp.sv
// ----------------------------------------------------------------------------
// oef_dp
// Datapath of the filter: state, configuration, shared dividers, square root
// and the blend multipliers, each step chosen by the sequencer's command.
// ----------------------------------------------------------------------------
`default_nettype none

module oef_dp #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  oef_pkg::oef_cmd_t                   cmd,
	output oef_pkg::oef_status_t                status,
	input  logic signed [oef_pkg::IO_WIDTH-1:0] raw_x,
	input  logic signed [oef_pkg::IO_WIDTH-1:0] raw_y,
	input  logic signed [oef_pkg::IO_WIDTH-1:0] raw_z,
	input  logic        [oef_pkg::DT_WIDTH-1:0] dt_us,
	input  logic                                restart,
	input  logic                                wr_en,
	input  logic   [oef_pkg::CFG_IDX_WIDTH-1:0] wr_index,
	input  logic       [oef_pkg::CFG_WIDTH-1:0] wr_data,
	output logic signed [oef_pkg::IO_WIDTH-1:0] out_x,
	output logic signed [oef_pkg::IO_WIDTH-1:0] out_y,
	output logic signed [oef_pkg::IO_WIDTH-1:0] out_z
);
	import oef_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int XW   = (CW > IO_WIDTH) ? CW : IO_WIDTH;
	localparam int DW   = CW + 1;
	localparam int NW   = DW + 20;
	localparam int NPW  = (NW > DIV_STEPS + 1) ? NW : DIV_STEPS + 1;
	localparam int HW   = NPW - DIV_STEPS;
	localparam int CMPW = (HW > DT_WIDTH) ? HW : DT_WIDTH;
	localparam int RPW  = RATE_WIDTH + ALPHA_WIDTH + 2;
	localparam int BPW  = CW + ALPHA_WIDTH + 2;

	localparam logic signed [XW-1:0]   CW_MAX = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [XW-1:0]   CW_MIN = ~CW_MAX;
	localparam logic signed [XW-1:0]   IO_MAX = {{(XW-IO_WIDTH+1){1'b0}}, {(IO_WIDTH-1){1'b1}}};
	localparam logic signed [XW-1:0]   IO_MIN = ~IO_MAX;
	localparam logic signed [CW+2:0]   V_MAX  = {4'b0000, {(CW-1){1'b1}}};
	localparam logic signed [CW+2:0]   V_MIN  = ~V_MAX;

	// Configuration and kept state.
	logic [CFG_WIDTH-1:0] min_cutoff_q, beta_q, deriv_cutoff_q;
	logic                 primed_q;
	logic                 fast_q;
	logic signed [CW-1:0]         value_q [AXES];
	logic signed [RATE_WIDTH-1:0] rate_q  [AXES];
	logic signed [CW-1:0]         raw_q   [AXES];
	logic [DT_WIDTH-1:0]          dt_q;

	// Rate division, one quotient bit per axis and cycle.
	logic                       neg_q  [AXES];
	logic [NPW-1:0]             n_q    [AXES];
	logic                       ovf_q  [AXES];
	logic [DT_WIDTH-1:0]        rem_q  [AXES];
	logic [DIV_STEPS-1:0]       nlo_q  [AXES];
	logic [DIV_STEPS-1:0]       quo_q  [AXES];
	logic signed [RPW-1:0]      rprod_q [AXES];
	logic signed [BPW-1:0]      bprod_q [AXES];

	// Alpha division, square root and cutoff.
	logic [W_WIDTH-1:0]     w_q;
	logic [DEN_WIDTH-1:0]   ar_q, den_q;
	logic [ALPHA_WIDTH-1:0] a_q;
	logic [SUM_WIDTH-1:0]   sum_q, sres_q, sbit_q;
	logic [CFG_WIDTH-1:0]   cut_q;
	logic signed [IO_WIDTH-1:0] out_q [AXES];

	logic signed [IO_WIDTH-1:0]   raw_in   [AXES];
	logic signed [XW-1:0]         raw_ext  [AXES];
	logic signed [CW-1:0]         raw_sat  [AXES];
	logic signed [DW-1:0]         diff     [AXES];
	logic [DW-1:0]                diff_mag [AXES];
	logic [NPW-1:0]               nprod    [AXES];
	logic [HW-1:0]                hi_part  [AXES];
	logic [DT_WIDTH:0]            dv_t     [AXES];
	logic                         dv_ge    [AXES];
	logic [DT_WIDTH-1:0]          dv_rem   [AXES];
	logic signed [RATE_WIDTH-1:0] rr       [AXES];
	logic signed [RATE_WIDTH:0]   rdiff    [AXES];
	logic signed [RPW-1:0]        rprod    [AXES];
	logic signed [RATE_WIDTH+1:0] rsh      [AXES];
	logic signed [RATE_WIDTH+2:0] rsum     [AXES];
	logic signed [RATE_WIDTH-1:0] rnew     [AXES];
	logic signed [BPW-1:0]        bprod    [AXES];
	logic signed [CW+1:0]         bsh      [AXES];
	logic signed [CW+2:0]         bsum     [AXES];
	logic signed [CW-1:0]         vnew     [AXES];
	logic signed [XW-1:0]         oext     [AXES];
	logic signed [IO_WIDTH-1:0]   osat     [AXES];

	logic                         bypass, primed_eff;
	logic signed [ALPHA_WIDTH:0]  a_s;
	logic [CFG_WIDTH-1:0]         acut;
	logic [WPROD_WIDTH-1:0]       awp;
	logic [NUM_WIDTH-1:0]         num;
	logic [DEN_WIDTH:0]           ar2;
	logic                         age;
	logic signed [RATE_WIDTH-1:0] sq_rate;
	logic [RATE_WIDTH-1:0]        sq_abs;
	logic [SUM_WIDTH-1:0]         sq;
	logic [SUM_WIDTH-1:0]         st;
	logic                         sge;
	logic [SUM_WIDTH-1:0]         bp;
	logic [SUM_WIDTH-8:0]         csum;

	assign raw_in[0] = raw_x;
	assign raw_in[1] = raw_y;
	assign raw_in[2] = raw_z;

	assign bypass     = (min_cutoff_q == '0) || (dt_us == '0);
	assign primed_eff = primed_q && !restart;
	assign a_s        = $signed({1'b0, a_q});
	assign status.fast = fast_q;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			raw_ext[i] = XW'(raw_in[i]);
			if (raw_ext[i] > CW_MAX)      raw_sat[i] = CW_MAX[CW-1:0];
			else if (raw_ext[i] < CW_MIN) raw_sat[i] = CW_MIN[CW-1:0];
			else                          raw_sat[i] = raw_ext[i][CW-1:0];

			diff[i]     = DW'(raw_q[i]) - DW'(value_q[i]);
			diff_mag[i] = diff[i][DW-1] ? unsigned'(-diff[i]) : unsigned'(diff[i]);
			nprod[i]    = NPW'(diff_mag[i]) * NPW'(MICRO);
			hi_part[i]  = n_q[i][NPW-1:DIV_STEPS];

			dv_t[i]   = {rem_q[i], nlo_q[i][DIV_STEPS-1]};
			dv_ge[i]  = (dv_t[i] >= {1'b0, dt_q});
			dv_rem[i] = dv_ge[i] ? DT_WIDTH'(dv_t[i] - {1'b0, dt_q}) : DT_WIDTH'(dv_t[i]);

			// A negative rate may reach one step further than a positive one.
			if (!neg_q[i]) begin
				rr[i] = (ovf_q[i] || quo_q[i][DIV_STEPS-1]) ? RATE_MAX : signed'(quo_q[i]);
			end else begin
				rr[i] = (ovf_q[i] || (quo_q[i][DIV_STEPS-1] && (|quo_q[i][DIV_STEPS-2:0])))
					? RATE_MIN : -signed'(quo_q[i]);
			end
			rdiff[i] = (RATE_WIDTH+1)'(rr[i]) - (RATE_WIDTH+1)'(rate_q[i]);
			rprod[i] = rdiff[i] * a_s;
			rsh[i]   = rprod_q[i][RPW-1:ALPHA_WIDTH];
			rsum[i]  = (RATE_WIDTH+3)'(rate_q[i]) + (RATE_WIDTH+3)'(rsh[i]);
			if (rsum[i] > (RATE_WIDTH+3)'(RATE_MAX))      rnew[i] = RATE_MAX;
			else if (rsum[i] < (RATE_WIDTH+3)'(RATE_MIN)) rnew[i] = RATE_MIN;
			else                                          rnew[i] = rsum[i][RATE_WIDTH-1:0];

			bprod[i] = diff[i] * a_s;
			bsh[i]   = bprod_q[i][BPW-1:ALPHA_WIDTH];
			bsum[i]  = (CW+3)'(value_q[i]) + (CW+3)'(bsh[i]);
			if (bsum[i] > V_MAX)      vnew[i] = V_MAX[CW-1:0];
			else if (bsum[i] < V_MIN) vnew[i] = V_MIN[CW-1:0];
			else                      vnew[i] = bsum[i][CW-1:0];

			oext[i] = fast_q ? XW'(raw_q[i]) : XW'(value_q[i]);
			if (oext[i] > IO_MAX)      osat[i] = IO_MAX[IO_WIDTH-1:0];
			else if (oext[i] < IO_MIN) osat[i] = IO_MIN[IO_WIDTH-1:0];
			else                       osat[i] = oext[i][IO_WIDTH-1:0];
		end
	end

	always_comb begin
		acut = cmd.use_cut ? cut_q : deriv_cutoff_q;
		awp  = WPROD_WIDTH'(acut) * WPROD_WIDTH'(TWO_PI_Q16);
		num  = NUM_WIDTH'(w_q) * NUM_WIDTH'(dt_q);
		ar2  = {ar_q, 1'b0};
		age  = (ar2 >= {1'b0, den_q});

		sq_rate = rate_q[cmd.axis];
		sq_abs  = sq_rate[RATE_WIDTH-1] ? unsigned'(-sq_rate) : unsigned'(sq_rate);
		sq      = SUM_WIDTH'(sq_abs[RATE_WIDTH-1:8]) * SUM_WIDTH'(sq_abs[RATE_WIDTH-1:8]);

		st  = sres_q + sbit_q;
		sge = (sum_q >= st);

		bp   = SUM_WIDTH'(beta_q) * SUM_WIDTH'(sres_q[SPEED_WIDTH-1:0]);
		csum = (SUM_WIDTH-7)'(bp[SUM_WIDTH-1:8]) + (SUM_WIDTH-7)'(min_cutoff_q);
	end

	// Control state: configuration, primed flag and path select.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_cutoff_q   <= MIN_CUTOFF_RST;
			beta_q         <= BETA_RST;
			deriv_cutoff_q <= DERIV_CUTOFF_RST;
			primed_q       <= 1'b0;
			fast_q         <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					CFG_MIN_CUTOFF:   min_cutoff_q   <= wr_data;
					CFG_BETA:         beta_q         <= wr_data;
					CFG_DERIV_CUTOFF: deriv_cutoff_q <= wr_data;
					default:          ;
				endcase
			end
			if (cmd.op == OP_LOAD) begin
				fast_q   <= bypass || !primed_eff;
				primed_q <= bypass ? primed_eff : 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				dt_q <= dt_us;
				for (int i = 0; i < AXES; i++) begin
					raw_q[i] <= raw_sat[i];
					if (!bypass && !primed_eff) begin
						value_q[i] <= raw_sat[i];
						rate_q[i]  <= '0;
					end
				end
			end
			OP_WCALC: begin
				w_q <= awp[WPROD_WIDTH-1:ALPHA_WIDTH];
				for (int i = 0; i < AXES; i++) begin
					neg_q[i] <= diff[i][DW-1];
					n_q[i]   <= nprod[i];
				end
			end
			OP_NUM: begin
				ar_q  <= DEN_WIDTH'(num);
				den_q <= DEN_WIDTH'(num) + TAU_SCALE;
				a_q   <= '0;
				for (int i = 0; i < AXES; i++) begin
					ovf_q[i] <= (CMPW'(hi_part[i]) >= CMPW'(dt_q));
					rem_q[i] <= DT_WIDTH'(hi_part[i]);
					nlo_q[i] <= n_q[i][DIV_STEPS-1:0];
					quo_q[i] <= '0;
				end
			end
			OP_DIV: begin
				for (int i = 0; i < AXES; i++) begin
					rem_q[i] <= dv_rem[i];
					nlo_q[i] <= {nlo_q[i][DIV_STEPS-2:0], 1'b0};
					quo_q[i] <= {quo_q[i][DIV_STEPS-2:0], dv_ge[i]};
				end
				if (cmd.alpha_step) begin
					ar_q <= age ? DEN_WIDTH'(ar2 - {1'b0, den_q}) : DEN_WIDTH'(ar2);
					a_q  <= {a_q[ALPHA_WIDTH-2:0], age};
				end
			end
			OP_RATE_MUL: begin
				for (int i = 0; i < AXES; i++) rprod_q[i] <= rprod[i];
			end
			OP_RATE_ACC: begin
				for (int i = 0; i < AXES; i++) rate_q[i] <= rnew[i];
				sum_q  <= '0;
				sres_q <= '0;
				sbit_q <= {2'b01, {(SUM_WIDTH-2){1'b0}}};
			end
			OP_SQ: sum_q <= sum_q + sq;
			OP_SQRT: begin
				if (sge) begin
					sum_q  <= sum_q - st;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			OP_CUT: cut_q <= (|csum[SUM_WIDTH-8:CFG_WIDTH]) ? '1 : csum[CFG_WIDTH-1:0];
			OP_BLEND_MUL: begin
				for (int i = 0; i < AXES; i++) bprod_q[i] <= bprod[i];
			end
			OP_BLEND_ACC: begin
				for (int i = 0; i < AXES; i++) value_q[i] <= vnew[i];
			end
			OP_WRITE: begin
				for (int i = 0; i < AXES; i++) out_q[i] <= osat[i];
			end
			default: ;
		endcase
	end

	assign out_x = out_q[0];
	assign out_y = out_q[1];
	assign out_z = out_q[2];

endmodule

`default_nettype wire

>>> design/oef_chk.sv
// ----------------------------------------------------------------------------
// oef_chk
// Port-level checks of the one euro vector filter core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "one_euro_vector_filter_core_assert.svh"

module oef_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_valid,
	input logic                                s_ready,
	input logic                                f_valid,
	input logic                                f_ready,
	input logic signed [oef_pkg::IO_WIDTH-1:0] f_x,
	input logic signed [oef_pkg::IO_WIDTH-1:0] f_y,
	input logic signed [oef_pkg::IO_WIDTH-1:0] f_z
);
	// A stalled result stays offered and unchanged.
	`OEF_ASSERT_NEXT(a_hold_valid, clk, arst_n, f_valid && !f_ready, f_valid)
	`OEF_ASSERT_NEXT(a_hold_data, clk, arst_n, f_valid && !f_ready, $stable(f_x) && $stable(f_y) && $stable(f_z))
	// Only one sample is worked on at a time.
	`OEF_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_valid && s_ready, !s_ready)
	// A new result appears only as the block goes back to waiting for samples.
	`OEF_ASSERT_SAME(a_result_frees_input, clk, arst_n, $rose(f_valid), s_ready)

endmodule

bind one_euro_vector_filter_core oef_chk u_oef_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_valid (sample.valid),
	.s_ready (sample.ready),
	.f_valid (filtered.valid),
	.f_ready (filtered.ready),
	.f_x     (filtered.out_x),
	.f_y     (filtered.out_y),
	.f_z     (filtered.out_z)
);

`default_nettype wire
